FILE: src/atd_pkg.sv
// atd_pkg: shared types, register indexes and codes of the airborne touchdown detector.
// Used by atd_step and airborne_touchdown_detector_top. No dependencies.
package atd_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_AIRBORNE_THR  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DESCEND_THR   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GROUNDED_THR  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PERSIST_SLACK = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_PEAK      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_DELTA     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_PEAK_FRACTION = 3'd6;

   localparam logic OP_OBSERVE = 1'b0;
   localparam logic OP_ARM     = 1'b1;

   localparam logic [1:0] TR_NONE       = 2'd0;
   localparam logic [1:0] TR_AIRBORNE   = 2'd1;
   localparam logic [1:0] TR_DESCENDING = 2'd2;
   localparam logic [1:0] TR_TOUCHDOWN  = 2'd3;

   localparam logic [22:0] PEAK_MAX = 23'h7FFFFF;

   localparam logic signed [23:0] RST_AIRBORNE_THR  = 24'sd256;
   localparam logic signed [23:0] RST_DESCEND_THR   = -24'sd128;
   localparam logic [22:0]        RST_GROUNDED_THR  = 23'd64;
   localparam logic [22:0]        RST_PERSIST_SLACK = 23'd128;
   localparam logic [22:0]        RST_MIN_PEAK      = 23'd512;
   localparam logic [22:0]        RST_MIN_DELTA     = 23'd256;
   localparam logic [15:0]        RST_PEAK_FRACTION = 16'd32768;

   typedef struct packed {
      logic signed [23:0] airborne_thr;
      logic signed [23:0] descend_thr;
      logic [22:0]        grounded_thr;
      logic [22:0]        persist_slack;
      logic [22:0]        min_peak;
      logic [22:0]        min_delta;
      logic [15:0]        peak_fraction;
   } atd_cfg_type;

   typedef struct packed {
      logic               tracking;
      logic [63:0]        cur_epoch;
      logic               boost_armed;
      logic               in_air;
      logic               falling;
      logic [22:0]        peak_down;
      logic signed [23:0] last_vertical;
      logic               last_valid;
      logic signed [23:0] recovery_ref;
      logic               recovery_pending;
   } atd_state_type;

   typedef struct packed {
      logic               opcode;
      logic               authority_on;
      logic [63:0]        epoch;
      logic               velocity_valid;
      logic [22:0]        speed_in;
      logic signed [23:0] vertical_speed;
   } atd_item_type;

   typedef struct packed {
      logic               active;
      logic [63:0]        epoch;
      logic [22:0]        speed;
      logic signed [23:0] vertical;
      logic [1:0]         transition;
      logic               touchdown;
      logic [22:0]        impact;
      logic               airborne;
      logic               descending;
      logic               arm_accepted;
   } atd_result_type;

   function automatic atd_state_type clear_flight(input atd_state_type s);
      atd_state_type r;
      r = s;
      r.boost_armed      = 1'b0;
      r.in_air           = 1'b0;
      r.falling          = 1'b0;
      r.peak_down        = '0;
      r.last_vertical    = '0;
      r.last_valid       = 1'b0;
      r.recovery_ref     = '0;
      r.recovery_pending = 1'b0;
      return r;
   endfunction

endpackage

FILE: src/atd_step.sv
// atd_step: next state and result of one item of the touchdown detector.
// Purely combinational; depends on atd_pkg.
module atd_step
   import atd_pkg::*;
(
   input  atd_cfg_type    cfg,
   input  atd_state_type  state_cur,
   input  atd_item_type   item,
   output atd_state_type  state_nxt,
   output atd_result_type result
);

   atd_state_type      s;
   atd_result_type     r;
   logic signed [23:0] vs;
   logic signed [24:0] neg_vs;
   logic [22:0]        down_mag;
   logic [23:0]        abs_vs;
   logic               settled;
   logic               persisted;
   logic signed [24:0] rise;
   logic [38:0]        need_frac;

   always_comb begin
      vs       = item.vertical_speed;
      neg_vs   = -$signed({vs[23], vs});
      if (!vs[23]) begin
         down_mag = '0;
      end else if (neg_vs[23]) begin
         down_mag = PEAK_MAX;
      end else begin
         down_mag = neg_vs[22:0];
      end
      abs_vs    = vs[23] ? neg_vs[23:0] : vs[23:0];
      rise      = $signed({vs[23], vs}) - $signed({state_cur.last_vertical[23],
                                                    state_cur.last_vertical});
      settled   = 1'b0;
      persisted = 1'b0;
      need_frac = '0;
      s = state_cur;
      r = '0;

      if (item.opcode == OP_ARM) begin
         if (s.tracking && item.epoch != 64'd0 && item.epoch == s.cur_epoch) begin
            s = clear_flight(s);
            s.boost_armed  = 1'b1;
            r.arm_accepted = 1'b1;
         end
         r.airborne   = s.in_air;
         r.descending = s.falling;
      end else if (!item.authority_on) begin
         s       = '0;
         r.epoch = item.epoch;
      end else begin
         if (!s.tracking || item.epoch != s.cur_epoch) begin
            s.tracking  = 1'b1;
            s.cur_epoch = item.epoch;
            s = clear_flight(s);
         end
         r.active = 1'b1;
         r.epoch  = s.cur_epoch;
         if (!item.velocity_valid) begin
            s.last_valid       = 1'b0;
            s.recovery_ref     = '0;
            s.recovery_pending = 1'b0;
         end else begin
            r.speed    = item.speed_in;
            r.vertical = vs;
            if (s.boost_armed && !s.in_air && vs >= cfg.airborne_thr) begin
               s.boost_armed      = 1'b0;
               s.in_air           = 1'b1;
               s.falling          = 1'b0;
               s.peak_down        = '0;
               s.recovery_ref     = '0;
               s.recovery_pending = 1'b0;
               r.transition       = TR_AIRBORNE;
            end
            if (s.in_air && !s.falling && vs <= cfg.descend_thr) begin
               s.falling          = 1'b1;
               s.peak_down        = down_mag;
               s.recovery_ref     = '0;
               s.recovery_pending = 1'b0;
               r.transition       = TR_DESCENDING;
            end else if (s.in_air && s.falling && vs[23]) begin
               if (down_mag > s.peak_down) begin
                  s.peak_down = down_mag;
               end
            end
            if (s.in_air && s.falling) begin
               settled   = abs_vs <= {1'b0, cfg.grounded_thr};
               persisted = s.recovery_pending &&
                  ($signed({{2{vs[23]}}, vs}) >=
                   $signed({{2{s.recovery_ref[23]}}, s.recovery_ref}) -
                   $signed({3'b000, cfg.persist_slack}));
               if (settled || persisted) begin
                  r.transition       = TR_TOUCHDOWN;
                  r.touchdown        = 1'b1;
                  r.impact           = s.peak_down;
                  s.in_air           = 1'b0;
                  s.falling          = 1'b0;
                  s.peak_down        = '0;
                  s.recovery_ref     = '0;
                  s.recovery_pending = 1'b0;
               end else begin
                  s.recovery_pending = 1'b0;
                  s.recovery_ref     = '0;
                  need_frac = 39'(s.peak_down) * 39'(cfg.peak_fraction);
                  if (s.last_valid && s.peak_down >= cfg.min_peak) begin
                     if ($signed({rise[24], rise}) >= $signed({3'b000, cfg.min_delta}) &&
                         $signed({rise[24], rise, 16'h0000}) >=
                         $signed({3'b000, need_frac})) begin
                        s.recovery_pending = 1'b1;
                        s.recovery_ref     = vs;
                     end
                  end
               end
            end
            s.last_vertical = vs;
            s.last_valid    = 1'b1;
         end
         r.airborne   = s.in_air;
         r.descending = s.falling;
      end
      state_nxt = s;
      result    = r;
   end

endmodule

FILE: src/airborne_touchdown_detector_top.sv
// airborne_touchdown_detector_top: input register, step logic, result register, CSRs.
// Depends on atd_pkg and atd_step.
//
// Usage:
//   req_* carries one item per handshake (req_valid high, req_stall low).
//   Each item yields exactly one result item on rsp_* (rsp_valid, rsp_stall).
//   csr_wr_en writes csr_wdata into register csr_index; write
//   only while no item is in flight. Indexes beyond the register list are ignored.
// Path: each item passes the input register, then the result register; the
//   state update and the one 23x16 multiply sit between them.
// Throughput: 1 item per cycle while the result is not stalled; the state
//   loop closes through state_ff alone.
// Stall: a stalled result holds in the result register; one more item waits
//   in the input register, after which req_stall rises until rsp is taken.
// Reset: synchronous, active high. Clears all tracking state and both
//   pipeline valids; registers return to their default values.
module airborne_touchdown_detector_top
   import atd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_opcode,
   input  logic                   req_authority_on,
   input  logic [63:0]            req_epoch,
   input  logic                   req_velocity_valid,
   input  logic [22:0]            req_speed_in,
   input  logic signed [23:0]     req_vertical_speed,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_active_out,
   output logic [63:0]            rsp_epoch_out,
   output logic [22:0]            rsp_speed_out,
   output logic signed [23:0]     rsp_vertical_out,
   output logic [1:0]             rsp_transition,
   output logic                   rsp_touchdown_flag,
   output logic [22:0]            rsp_impact_speed,
   output logic                   rsp_airborne_out,
   output logic                   rsp_descending_out,
   output logic                   rsp_arm_accepted,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   atd_cfg_type    cfg_ff;
   atd_state_type  state_ff;
   atd_state_type  state_in;
   atd_item_type   item_ff;
   logic           item_vld_ff;
   atd_result_type rsp_ff;
   atd_result_type rsp_in;
   logic           rsp_vld_ff;
   logic           advance;

   assign advance   = !rsp_vld_ff || !rsp_stall;
   assign req_stall = item_vld_ff && !advance;

   atd_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .item      (item_ff),
      .state_nxt (state_in),
      .result    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.airborne_thr  <= RST_AIRBORNE_THR;
         cfg_ff.descend_thr   <= RST_DESCEND_THR;
         cfg_ff.grounded_thr  <= RST_GROUNDED_THR;
         cfg_ff.persist_slack <= RST_PERSIST_SLACK;
         cfg_ff.min_peak      <= RST_MIN_PEAK;
         cfg_ff.min_delta     <= RST_MIN_DELTA;
         cfg_ff.peak_fraction <= RST_PEAK_FRACTION;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_AIRBORNE_THR:  cfg_ff.airborne_thr  <= $signed(csr_wdata);
            REG_DESCEND_THR:   cfg_ff.descend_thr   <= $signed(csr_wdata);
            REG_GROUNDED_THR:  cfg_ff.grounded_thr  <= csr_wdata[22:0];
            REG_PERSIST_SLACK: cfg_ff.persist_slack <= csr_wdata[22:0];
            REG_MIN_PEAK:      cfg_ff.min_peak      <= csr_wdata[22:0];
            REG_MIN_DELTA:     cfg_ff.min_delta     <= csr_wdata[22:0];
            REG_PEAK_FRACTION: cfg_ff.peak_fraction <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         state_ff    <= '0;
      end else begin
         if (!req_stall) begin
            item_vld_ff <= req_valid;
         end
         if (advance) begin
            rsp_vld_ff <= item_vld_ff;
            if (item_vld_ff) begin
               state_ff <= state_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff.opcode         <= req_opcode;
         item_ff.authority_on   <= req_authority_on;
         item_ff.epoch          <= req_epoch;
         item_ff.velocity_valid <= req_velocity_valid;
         item_ff.speed_in       <= req_speed_in;
         item_ff.vertical_speed <= req_vertical_speed;
      end
      if (advance && item_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_active_out     = rsp_ff.active;
   assign rsp_epoch_out      = rsp_ff.epoch;
   assign rsp_speed_out      = rsp_ff.speed;
   assign rsp_vertical_out   = rsp_ff.vertical;
   assign rsp_transition     = rsp_ff.transition;
   assign rsp_touchdown_flag = rsp_ff.touchdown;
   assign rsp_impact_speed   = rsp_ff.impact;
   assign rsp_airborne_out   = rsp_ff.airborne;
   assign rsp_descending_out = rsp_ff.descending;
   assign rsp_arm_accepted   = rsp_ff.arm_accepted;

   a_fall_needs_air: assert property (@(posedge clock) disable iff (reset)
      state_ff.falling |-> state_ff.in_air)
      else $error("falling without in_air");

   a_pending_needs_fall: assert property (@(posedge clock) disable iff (reset)
      state_ff.recovery_pending |-> state_ff.falling)
      else $error("recovery pending outside descent");

   a_item_reaches_rsp: assert property (@(posedge clock) disable iff (reset)
      (item_vld_ff && advance) |=> rsp_valid)
      else $error("advanced item produced no result");

   a_touchdown_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_touchdown_flag) |-> (rsp_transition == TR_TOUCHDOWN))
      else $error("touchdown flag without touchdown transition");

   a_impact_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_touchdown_flag) |-> (rsp_impact_speed == 23'd0))
      else $error("impact speed without touchdown");

endmodule

FILE: tb/touchdown_checker.sv
// touchdown_checker: watches the request, result and CSR ports of the detector,
// predicts each result item from its own copy of the flight state, and compares.
// Depends on atd_pkg for the item and result types and the codes.
module touchdown_checker
   import atd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   req_opcode,
   input  logic                   req_authority_on,
   input  logic [63:0]            req_epoch,
   input  logic                   req_velocity_valid,
   input  logic [22:0]            req_speed_in,
   input  logic signed [23:0]     req_vertical_speed,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_active_out,
   input  logic [63:0]            rsp_epoch_out,
   input  logic [22:0]            rsp_speed_out,
   input  logic signed [23:0]     rsp_vertical_out,
   input  logic [1:0]             rsp_transition,
   input  logic                   rsp_touchdown_flag,
   input  logic [22:0]            rsp_impact_speed,
   input  logic                   rsp_airborne_out,
   input  logic                   rsp_descending_out,
   input  logic                   rsp_arm_accepted,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // thresholds as last written
   longint thr_air, thr_desc, thr_gnd, slack, pk_min, dl_min, pk_frac;

   // flight state
   logic        trk, armed, in_air, falling, last_ok, rec_pend;
   logic [63:0] cur_ep;
   longint      peak, last_vert, rec_ref;

   atd_result_type reports_due[$];
   int mismatches = 0;
   int due_count  = 0;
   int checked    = 0;

   assign fail_count  = mismatches;
   assign outstanding = due_count;

   task automatic report_mismatch(input string msg);
      if (mismatches < 40)
         $display("[%0t] MISMATCH result %0d: %s", $time, checked, msg);
      mismatches++;
   endtask

   function automatic void drop_flight();
      armed     = 1'b0;
      in_air    = 1'b0;
      falling   = 1'b0;
      peak      = 0;
      last_vert = 0;
      last_ok   = 1'b0;
      rec_ref   = 0;
      rec_pend  = 1'b0;
   endfunction

   function automatic longint clip_peak(input longint d);
      if (d < 0) return 0;
      if (d > longint'(PEAK_MAX)) return longint'(PEAK_MAX);
      return d;
   endfunction

   function automatic atd_result_type predict_flight_report(input atd_item_type it);
      atd_result_type r;
      longint vs, mag, d, rise;
      logic settled, persisted;
      r = '0;
      vs = $signed(it.vertical_speed);
      if (it.opcode == OP_ARM) begin
         if (trk && it.epoch != 64'd0 && it.epoch == cur_ep) begin
            drop_flight();
            armed = 1'b1;
            r.arm_accepted = 1'b1;
         end
         r.airborne   = in_air;
         r.descending = falling;
         return r;
      end
      if (!it.authority_on) begin
         trk    = 1'b0;
         cur_ep = '0;
         drop_flight();
         r.epoch = it.epoch;
         return r;
      end
      if (!trk || it.epoch != cur_ep) begin
         trk    = 1'b1;
         cur_ep = it.epoch;
         drop_flight();
      end
      r.active = 1'b1;
      r.epoch  = cur_ep;
      if (!it.velocity_valid) begin
         last_ok  = 1'b0;
         rec_ref  = 0;
         rec_pend = 1'b0;
         r.airborne   = in_air;
         r.descending = falling;
         return r;
      end
      r.speed    = it.speed_in;
      r.vertical = it.vertical_speed;
      if (armed && !in_air && vs >= thr_air) begin
         armed    = 1'b0;
         in_air   = 1'b1;
         falling  = 1'b0;
         peak     = 0;
         rec_ref  = 0;
         rec_pend = 1'b0;
         r.transition = TR_AIRBORNE;
      end
      if (in_air && !falling && vs <= thr_desc) begin
         falling  = 1'b1;
         peak     = clip_peak(-vs);
         rec_ref  = 0;
         rec_pend = 1'b0;
         r.transition = TR_DESCENDING;
      end else if (in_air && falling && vs < 0) begin
         d = clip_peak(-vs);
         if (d > peak) peak = d;
      end
      if (in_air && falling) begin
         mag       = (vs < 0) ? -vs : vs;
         settled   = (mag <= thr_gnd);
         persisted = rec_pend && (vs >= rec_ref - slack);
         if (settled || persisted) begin
            r.transition = TR_TOUCHDOWN;
            r.touchdown  = 1'b1;
            r.impact     = 23'(peak);
            in_air   = 1'b0;
            falling  = 1'b0;
            peak     = 0;
            rec_ref  = 0;
            rec_pend = 1'b0;
         end else begin
            rec_pend = 1'b0;
            rec_ref  = 0;
            if (last_ok && peak >= pk_min) begin
               rise = vs - last_vert;
               if (rise >= dl_min && rise * 65536 >= peak * pk_frac) begin
                  rec_pend = 1'b1;
                  rec_ref  = vs;
               end
            end
         end
      end
      last_vert = vs;
      last_ok   = 1'b1;
      r.airborne   = in_air;
      r.descending = falling;
      return r;
   endfunction

   always @(posedge clock) begin
      atd_item_type   it;
      atd_result_type got, want;
      if (reset) begin
         thr_air  = $signed(RST_AIRBORNE_THR);
         thr_desc = $signed(RST_DESCEND_THR);
         thr_gnd  = RST_GROUNDED_THR;
         slack    = RST_PERSIST_SLACK;
         pk_min   = RST_MIN_PEAK;
         dl_min   = RST_MIN_DELTA;
         pk_frac  = RST_PEAK_FRACTION;
         trk      = 1'b0;
         cur_ep   = '0;
         drop_flight();
         reports_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_AIRBORNE_THR:  thr_air  = $signed(csr_wdata);
               REG_DESCEND_THR:   thr_desc = $signed(csr_wdata);
               REG_GROUNDED_THR:  thr_gnd  = csr_wdata[22:0];
               REG_PERSIST_SLACK: slack    = csr_wdata[22:0];
               REG_MIN_PEAK:      pk_min   = csr_wdata[22:0];
               REG_MIN_DELTA:     dl_min   = csr_wdata[22:0];
               REG_PEAK_FRACTION: pk_frac  = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got.active       = rsp_active_out;
            got.epoch        = rsp_epoch_out;
            got.speed        = rsp_speed_out;
            got.vertical     = rsp_vertical_out;
            got.transition   = rsp_transition;
            got.touchdown    = rsp_touchdown_flag;
            got.impact       = rsp_impact_speed;
            got.airborne     = rsp_airborne_out;
            got.descending   = rsp_descending_out;
            got.arm_accepted = rsp_arm_accepted;
            if (reports_due.size() == 0) begin
               report_mismatch("result item with no expectation waiting");
            end else begin
               want = reports_due.pop_front();
               if (got.active !== want.active)
                  report_mismatch($sformatf("active_out %h want %h", got.active, want.active));
               if (got.epoch !== want.epoch)
                  report_mismatch($sformatf("epoch_out %h want %h", got.epoch, want.epoch));
               if (got.speed !== want.speed)
                  report_mismatch($sformatf("speed_out %h want %h", got.speed, want.speed));
               if (got.vertical !== want.vertical)
                  report_mismatch($sformatf("vertical_out %h want %h",
                                            got.vertical, want.vertical));
               if (got.transition !== want.transition)
                  report_mismatch($sformatf("transition %h want %h",
                                            got.transition, want.transition));
               if (got.touchdown !== want.touchdown)
                  report_mismatch($sformatf("touchdown_flag %h want %h",
                                            got.touchdown, want.touchdown));
               if (got.impact !== want.impact)
                  report_mismatch($sformatf("impact_speed %h want %h", got.impact, want.impact));
               if (got.airborne !== want.airborne)
                  report_mismatch($sformatf("airborne_out %h want %h",
                                            got.airborne, want.airborne));
               if (got.descending !== want.descending)
                  report_mismatch($sformatf("descending_out %h want %h",
                                            got.descending, want.descending));
               if (got.arm_accepted !== want.arm_accepted)
                  report_mismatch($sformatf("arm_accepted %h want %h",
                                            got.arm_accepted, want.arm_accepted));
            end
            checked++;
         end
         if (req_valid && !req_stall) begin
            it.opcode         = req_opcode;
            it.authority_on   = req_authority_on;
            it.epoch          = req_epoch;
            it.velocity_valid = req_velocity_valid;
            it.speed_in       = req_speed_in;
            it.vertical_speed = req_vertical_speed;
            reports_due.push_back(predict_flight_report(it));
         end
      end
      due_count <= reports_due.size();
   end

endmodule

FILE: tb/testbench.sv
// testbench: clock, reset, item stimulus, CSR phases and the verdict for the
// airborne touchdown detector. Depends on atd_pkg, the detector RTL and touchdown_checker.
module testbench;
   import atd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   req_valid          = 1'b0;
   logic                   req_opcode         = OP_OBSERVE;
   logic                   req_authority_on   = 1'b0;
   logic [63:0]            req_epoch          = '0;
   logic                   req_velocity_valid = 1'b0;
   logic [22:0]            req_speed_in       = '0;
   logic signed [23:0]     req_vertical_speed = '0;
   logic                   rsp_stall          = 1'b0;
   logic                   csr_wr_en          = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index          = REG_AIRBORNE_THR;
   logic [CSR_DATA_W-1:0]  csr_wdata          = '0;

   logic                   req_stall;
   logic                   rsp_valid;
   logic                   rsp_active_out;
   logic [63:0]            rsp_epoch_out;
   logic [22:0]            rsp_speed_out;
   logic signed [23:0]     rsp_vertical_out;
   logic [1:0]             rsp_transition;
   logic                   rsp_touchdown_flag;
   logic [22:0]            rsp_impact_speed;
   logic                   rsp_airborne_out;
   logic                   rsp_descending_out;
   logic                   rsp_arm_accepted;
   int                     fail_count;
   int                     outstanding;

   int          send_idle   = 18;
   int          recv_idle   = 77;
   int          holds_asked = 0;
   int          holds_done  = 0;
   int          hold_left   = 0;
   int          sent_items  = 0;
   logic [63:0] ep          = 64'd1;
   atd_cfg_type cfg_now;

   airborne_touchdown_detector_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_authority_on   (req_authority_on),
      .req_epoch          (req_epoch),
      .req_velocity_valid (req_velocity_valid),
      .req_speed_in       (req_speed_in),
      .req_vertical_speed (req_vertical_speed),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_active_out     (rsp_active_out),
      .rsp_epoch_out      (rsp_epoch_out),
      .rsp_speed_out      (rsp_speed_out),
      .rsp_vertical_out   (rsp_vertical_out),
      .rsp_transition     (rsp_transition),
      .rsp_touchdown_flag (rsp_touchdown_flag),
      .rsp_impact_speed   (rsp_impact_speed),
      .rsp_airborne_out   (rsp_airborne_out),
      .rsp_descending_out (rsp_descending_out),
      .rsp_arm_accepted   (rsp_arm_accepted),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   touchdown_checker checker_i (.*);

   always #1 clock = ~clock;

   initial begin
      #2000000;
      $display("airborne_touchdown_detector_top test failed");
      $finish;
   end

   // receiver: random stall, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         rsp_stall  <= 1'b1;
         hold_left  <= 300;
         holds_done <= holds_done + 1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < recv_idle);
      end
   end

   function automatic longint urange(input longint lo, input longint hi);
      return lo + longint'($urandom_range(32'(hi - lo), 0));
   endfunction

   function automatic logic signed [23:0] fit_vertical(input longint v);
      if (v > 8388607) return 24'sh7FFFFF;
      if (v < -8388608) return 24'sh800000;
      return 24'(v);
   endfunction

   function automatic logic [63:0] pick_epoch();
      case ($urandom_range(9, 0))
         0:       return '0;
         1, 2, 3: return {$urandom, $urandom};
         default: return 64'($urandom_range(4, 1));
      endcase
   endfunction

   function automatic atd_item_type obs_item(input logic [63:0] e, input logic auth,
                                             input logic ok, input longint v);
      atd_item_type it;
      it.opcode         = OP_OBSERVE;
      it.authority_on   = auth;
      it.epoch          = e;
      it.velocity_valid = ok;
      it.speed_in       = 23'($urandom);
      it.vertical_speed = fit_vertical(v);
      return it;
   endfunction

   function automatic atd_item_type arm_item(input logic [63:0] e);
      atd_item_type it;
      it = obs_item(e, 1'($urandom), 1'($urandom), longint'($signed(24'($urandom))));
      it.opcode = OP_ARM;
      return it;
   endfunction

   task automatic send_item(input atd_item_type it);
      while ($urandom_range(99, 0) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= it.opcode;
      req_authority_on   <= it.authority_on;
      req_epoch          <= it.epoch;
      req_velocity_valid <= it.velocity_valid;
      req_speed_in       <= it.speed_in;
      req_vertical_speed <= it.vertical_speed;
      do @(posedge clock); while (req_stall);
      sent_items++;
   endtask

   task automatic send_obs(input longint v);
      send_item(obs_item(ep, 1'b1, $urandom_range(99, 0) >= 7, v));
   endtask

   task automatic send_noise();
      atd_item_type it;
      it.opcode         = 1'($urandom);
      it.authority_on   = ($urandom_range(9, 0) != 0);
      it.epoch          = $urandom_range(1, 0) ? ep : {$urandom, $urandom};
      it.velocity_valid = 1'($urandom);
      it.speed_in       = 23'($urandom);
      it.vertical_speed = 24'($urandom);
      send_item(it);
   endtask

   // one takeoff, descent and landing attempt shaped by the current thresholds
   task automatic run_flight();
      longint air, dsc, gnd, v, last, pk, need;
      air  = $signed(cfg_now.airborne_thr);
      dsc  = $signed(cfg_now.descend_thr);
      gnd  = cfg_now.grounded_thr;
      last = 0;
      pk   = 0;
      if ($urandom_range(3, 0) == 0) ep = pick_epoch();
      send_item(obs_item(ep, 1'b1, 1'b1, 0));
      send_item(arm_item(($urandom_range(9, 0) == 0) ? ep + 64'd1 : ep));
      repeat ($urandom_range(3, 1)) send_obs(air + urange(-100, 1500));
      repeat ($urandom_range(5, 1)) begin
         v = dsc - urange(0, ($urandom_range(7, 0) == 0) ? 8000000 : 4000);
         send_obs(v);
         last = v;
         if (-v > pk) pk = -v;
      end
      case ($urandom_range(2, 0))
         0: send_obs(urange(-gnd - 8, gnd + 8));
         1: begin
            need = (pk * longint'(cfg_now.peak_fraction)) >>> 16;
            if (need < longint'(cfg_now.min_delta)) need = cfg_now.min_delta;
            v = last + need + urange(-20, 300);
            send_obs(v);
            send_obs(v - longint'(cfg_now.persist_slack) + urange(-40, 40));
         end
         default: repeat ($urandom_range(4, 1)) send_obs(urange(-3000, 3000));
      endcase
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_config(input atd_cfg_type c);
      csr_wr_en <= 1'b1;
      csr_index <= REG_AIRBORNE_THR;
      csr_wdata <= c.airborne_thr;
      @(posedge clock);
      csr_index <= REG_DESCEND_THR;
      csr_wdata <= c.descend_thr;
      @(posedge clock);
      csr_index <= REG_GROUNDED_THR;
      csr_wdata <= {1'b0, c.grounded_thr};
      @(posedge clock);
      csr_index <= REG_PERSIST_SLACK;
      csr_wdata <= {1'b0, c.persist_slack};
      @(posedge clock);
      csr_index <= REG_MIN_PEAK;
      csr_wdata <= {1'b0, c.min_peak};
      @(posedge clock);
      csr_index <= REG_MIN_DELTA;
      csr_wdata <= {1'b0, c.min_delta};
      @(posedge clock);
      csr_index <= REG_PEAK_FRACTION;
      csr_wdata <= {8'd0, c.peak_fraction};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_now = c;
   endtask

   function automatic atd_cfg_type sane_config();
      atd_cfg_type c;
      c.airborne_thr  = 24'(urange(128, 1024));
      c.descend_thr   = 24'(urange(-1024, -64));
      c.grounded_thr  = 23'(urange(16, 256));
      c.persist_slack = 23'(urange(0, 512));
      c.min_peak      = 23'(urange(128, 2048));
      c.min_delta     = 23'(urange(64, 512));
      c.peak_fraction = 16'($urandom);
      return c;
   endfunction

   function automatic atd_cfg_type wild_config();
      atd_cfg_type c;
      c.airborne_thr  = 24'($urandom);
      c.descend_thr   = 24'($urandom);
      c.grounded_thr  = 23'($urandom);
      c.persist_slack = 23'($urandom);
      c.min_peak      = 23'($urandom);
      c.min_delta     = 23'($urandom);
      c.peak_fraction = 16'($urandom);
      return c;
   endfunction

   task automatic run_phase(input atd_cfg_type c, input int s_idle, input int r_idle,
                            input int goal);
      wait_drained();
      load_config(c);
      send_idle = s_idle;
      recv_idle <= r_idle;
      while (sent_items < goal) begin
         if ($urandom_range(99, 0) < 15)
            repeat ($urandom_range(3, 1)) send_noise();
         else
            run_flight();
      end
   endtask

   initial begin
      atd_item_type it;
      atd_cfg_type  c;
      cfg_now = '{RST_AIRBORNE_THR, RST_DESCEND_THR, RST_GROUNDED_THR, RST_PERSIST_SLACK,
                  RST_MIN_PEAK, RST_MIN_DELTA, RST_PEAK_FRACTION};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed items on the reset thresholds
      send_item(arm_item(64'd5));                       // arm with tracking off
      send_item(obs_item('1, 1'b0, 1'b1, 100));         // authority off
      send_item(obs_item(64'd0, 1'b1, 1'b1, 0));        // first activation, epoch zero
      send_item(arm_item(64'd0));                       // zero epoch never arms
      it = obs_item(64'd1, 1'b1, 1'b1, 8388607);        // new epoch, top speeds
      it.speed_in = '1;
      send_item(it);
      send_item(arm_item(64'd2));                       // wrong epoch
      send_item(arm_item(64'd1));
      send_item(obs_item(64'd1, 1'b1, 1'b1, 255));
      send_item(obs_item(64'd1, 1'b1, 1'b1, 256));      // airborne at threshold
      send_item(obs_item(64'd1, 1'b1, 1'b1, -128));     // descending at threshold
      send_item(obs_item(64'd1, 1'b1, 1'b1, -8388608)); // peak saturates
      send_item(obs_item(64'd1, 1'b1, 1'b0, -5000));    // unreadable
      send_item(obs_item(64'd1, 1'b1, 1'b1, 64));       // settled touchdown
      // sharp recovery that persists within the slack
      send_item(arm_item(64'd1));
      send_item(obs_item(64'd1, 1'b1, 1'b1, 300));
      send_item(obs_item(64'd1, 1'b1, 1'b1, -1000));
      send_item(obs_item(64'd1, 1'b1, 1'b1, -2000));
      send_item(obs_item(64'd1, 1'b1, 1'b1, -900));
      send_item(obs_item(64'd1, 1'b1, 1'b1, -1028));
      // unreadable sample drops the pending recovery
      send_item(arm_item(64'd1));
      send_item(obs_item(64'd1, 1'b1, 1'b1, 300));
      send_item(obs_item(64'd1, 1'b1, 1'b1, -2000));
      send_item(obs_item(64'd1, 1'b1, 1'b1, -900));
      send_item(obs_item(64'd1, 1'b1, 1'b0, 0));
      send_item(obs_item(64'd1, 1'b1, 1'b1, -950));
      send_item(obs_item(64'd1, 1'b1, 1'b1, -64));

      run_phase(sane_config(), 18, 77, 200);
      c = '{24'sh800000, 24'sh800000, '0, '0, '0, '0, '0};
      run_phase(c, 18, 77, 370);
      run_phase(sane_config(), 77, 18, 540);
      c = '{24'sh7FFFFF, 24'sh7FFFFF, '1, '1, '1, '1, '1};
      run_phase(c, 77, 18, 640);
      c = sane_config();
      c.min_peak      = '0;
      c.peak_fraction = '1;
      run_phase(c, 77, 18, 700);
      run_phase(wild_config(), 0, 0, 800);

      // long receiver hold-off while items keep coming, then a full pause
      wait_drained();
      load_config(sane_config());
      send_idle = 0;
      recv_idle <= 0;
      holds_asked <= holds_asked + 1;
      repeat (12) run_flight();
      wait_drained();
      while (sent_items < 1020) run_flight();

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("airborne_touchdown_detector_top test passed");
      else
         $display("airborne_touchdown_detector_top test failed");
      $finish;
   end

endmodule

FILE: files.f
src/atd_pkg.sv
src/atd_step.sv
src/airborne_touchdown_detector_top.sv
tb/touchdown_checker.sv
tb/testbench.sv
